// ===== sv/bf4_pkg.sv =====
// bf4_pkg: shared types and codes for the boundary fill engine
// command codes, controller states, command and status structs
// no dependencies
package bf4_pkg;

    localparam int COLOR_W = 24;
    localparam int COUNT_W = 15;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_COLOR = 1'd1;

    localparam logic [COLOR_W-1:0] FILL_COLOR_RESET     = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BOUNDARY_COLOR_RESET = 24'h000000;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2
    } command_t;

    // neighbour order for pushes
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL_INIT,
        ST_POP,
        ST_LATCH,
        ST_FETCH,
        ST_CHECK,
        ST_PUSH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_step;
        logic fill_init;
        logic pop;
        logic latch_cur;
        logic fetch;
        logic paint;
        logic push_nb;
        dir_t dir;
        logic wr_pixel;
        logic rd_pixel;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_frame;
        logic       sp_zero;
        logic       clr_last;
        logic       paint_ok;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== sv/bf4_ram.sv =====
// bf4_ram: generic single write port, single read port ram
// registered read with read enable; no dependencies
module bf4_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bf4_ctrl.sv =====
// bf4_ctrl: sequencer for clear pass, pixel access and fill loop
// depends on bf4_pkg
module bf4_ctrl
    import bf4_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    dir_t   dir_reg, dir_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            dir_reg   <= DIR_RIGHT;
        end else begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dir_next   = dir_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.cmd == CMD_FILL) begin
                    state_next = ST_FILL_INIT;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_FILL_INIT: state_next = ST_POP;
            ST_POP: begin
                if (status.sp_zero) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_CHECK;
            ST_CHECK: begin
                dir_next = DIR_RIGHT;
                if (status.paint_ok) begin
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_PUSH: begin
                dir_next = dir_t'(dir_reg + 2'd1);
                if (dir_reg == DIR_UP) begin
                    state_next = ST_POP;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        cmd.dir = dir_reg;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_EXEC: begin
                cmd.wr_pixel = (status.cmd == CMD_WRITE);
                cmd.rd_pixel = (status.cmd == CMD_READ);
            end
            ST_FILL_INIT: cmd.fill_init = 1'b1;
            ST_POP:       cmd.pop = !status.sp_zero;
            ST_LATCH:     cmd.latch_cur = 1'b1;
            ST_FETCH:     cmd.fetch = 1'b1;
            ST_CHECK:     cmd.paint = status.paint_ok;
            ST_PUSH:      cmd.push_nb = 1'b1;
            ST_RESULT:    cmd.load_result = status.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/bf4_dp.sv =====
// bf4_dp: datapath with frame store, seed stack, counters and result register
// depends on bf4_pkg and bf4_ram
module bf4_dp
    import bf4_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128,
    parameter int STACK_DEPTH  = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [1:0]           s_command,
    input  logic [6:0]           s_x_coord,
    input  logic [6:0]           s_y_coord,
    input  logic [COLOR_W-1:0]   s_pixel_color,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_read_color,
    output logic [COUNT_W-1:0]   m_filled_count,
    output logic                 m_stack_overflow,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int XW     = $clog2(FRAME_WIDTH);
    localparam int YW     = $clog2(FRAME_HEIGHT);
    localparam int PAW    = $clog2(PIXELS);
    localparam int SAW    = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int EW     = XW + YW;
    localparam logic [XW-1:0]  X_LAST     = XW'(FRAME_WIDTH - 1);
    localparam logic [YW-1:0]  Y_LAST     = YW'(FRAME_HEIGHT - 1);
    localparam logic [PAW-1:0] PIX_LAST   = PAW'(PIXELS - 1);
    localparam logic [SPW-1:0] STACK_FULL = SPW'(STACK_DEPTH);

    // configuration
    logic [COLOR_W-1:0] fill_color_reg;
    logic [COLOR_W-1:0] boundary_color_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_color_reg     <= FILL_COLOR_RESET;
            boundary_color_reg <= BOUNDARY_COLOR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FILL_COLOR:     fill_color_reg <= cfg_data;
                REG_BOUNDARY_COLOR: boundary_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured word and current pixel
    logic [1:0]         cmd_reg;
    logic               in_frame_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [XW-1:0]      cur_x_reg;
    logic [YW-1:0]      cur_y_reg;
    logic [PAW-1:0]     pix_addr;

    logic [PAW-1:0]     clr_addr_reg;
    logic [SPW-1:0]     sp_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ovf_reg;

    logic               frame_we;
    logic [PAW-1:0]     frame_waddr;
    logic [COLOR_W-1:0] frame_wdata;
    logic [COLOR_W-1:0] frame_rdata;

    logic               stack_we;
    logic [SAW-1:0]     stack_waddr;
    logic [EW-1:0]      stack_wdata;
    logic [SAW-1:0]     stack_raddr;
    logic [EW-1:0]      stack_rdata;

    logic [XW-1:0]      nb_x;
    logic [YW-1:0]      nb_y;
    logic               nb_ok;
    logic               stack_full;
    logic [SPW-1:0]     sp_dec;

    assign pix_addr = PAW'(cur_y_reg) * PAW'(FRAME_WIDTH) + PAW'(cur_x_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg      <= s_command;
            in_frame_reg <= (int'(s_x_coord) < FRAME_WIDTH) && (int'(s_y_coord) < FRAME_HEIGHT);
            color_reg    <= s_pixel_color;
            cur_x_reg    <= XW'(s_x_coord);
            cur_y_reg    <= YW'(s_y_coord);
        end else if (cmd.latch_cur) begin
            cur_x_reg <= stack_rdata[XW-1:0];
            cur_y_reg <= stack_rdata[EW-1:XW];
        end
    end

    // clear pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + PAW'(1);
        end
    end

    // neighbour of the current pixel
    always_comb begin
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        nb_ok = 1'b0;
        case (cmd.dir)
            DIR_RIGHT: begin
                nb_x  = cur_x_reg + XW'(1);
                nb_ok = (cur_x_reg != X_LAST);
            end
            DIR_LEFT: begin
                nb_x  = cur_x_reg - XW'(1);
                nb_ok = (cur_x_reg != '0);
            end
            DIR_DOWN: begin
                nb_y  = cur_y_reg + YW'(1);
                nb_ok = (cur_y_reg != Y_LAST);
            end
            DIR_UP: begin
                nb_y  = cur_y_reg - YW'(1);
                nb_ok = (cur_y_reg != '0);
            end
            default: nb_ok = 1'b0;
        endcase
    end

    assign stack_full = (sp_reg == STACK_FULL);
    assign sp_dec     = sp_reg - SPW'(1);

    // stack pointer, paint count, overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.fill_init) begin
                sp_reg    <= in_frame_reg ? SPW'(1) : '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (cmd.pop) begin
                sp_reg <= sp_dec;
            end else if (cmd.push_nb && nb_ok) begin
                if (stack_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    sp_reg <= sp_reg + SPW'(1);
                end
            end
            if (cmd.paint && (count_reg != '1)) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    // frame store ports
    always_comb begin
        frame_we    = 1'b0;
        frame_waddr = pix_addr;
        frame_wdata = fill_color_reg;
        if (cmd.clr_step) begin
            frame_we    = 1'b1;
            frame_waddr = clr_addr_reg;
            frame_wdata = '0;
        end else if (cmd.wr_pixel) begin
            frame_we    = in_frame_reg;
            frame_wdata = color_reg;
        end else if (cmd.paint) begin
            frame_we = 1'b1;
        end
    end

    bf4_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PIXELS)
    ) u_frame (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .re    (cmd.fetch || cmd.rd_pixel),
        .raddr (pix_addr),
        .rdata (frame_rdata)
    );

    // seed stack ports
    always_comb begin
        stack_we    = 1'b0;
        stack_waddr = sp_reg[SAW-1:0];
        stack_wdata = {nb_y, nb_x};
        if (cmd.fill_init) begin
            stack_we    = in_frame_reg;
            stack_waddr = '0;
            stack_wdata = {cur_y_reg, cur_x_reg};
        end else if (cmd.push_nb) begin
            stack_we = nb_ok && !stack_full;
        end
    end

    assign stack_raddr = sp_dec[SAW-1:0];

    bf4_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (cmd.pop),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // result register
    logic               m_valid_reg;
    logic [COLOR_W-1:0] m_read_color_reg;
    logic [COUNT_W-1:0] m_filled_count_reg;
    logic               m_stack_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_read_color_reg     <= '0;
            m_filled_count_reg   <= '0;
            m_stack_overflow_reg <= 1'b0;
            case (cmd_reg)
                CMD_READ: begin
                    m_read_color_reg <= in_frame_reg ? frame_rdata : '0;
                end
                CMD_FILL: begin
                    m_filled_count_reg   <= count_reg;
                    m_stack_overflow_reg <= ovf_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_color     = m_read_color_reg;
    assign m_filled_count   = m_filled_count_reg;
    assign m_stack_overflow = m_stack_overflow_reg;

    assign status.cmd      = cmd_reg;
    assign status.in_frame = in_frame_reg;
    assign status.sp_zero  = (sp_reg == '0);
    assign status.clr_last = (clr_addr_reg == PIX_LAST);
    assign status.paint_ok = (frame_rdata != boundary_color_reg) &&
                             (frame_rdata != fill_color_reg);
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// ===== sv/boundary_fill_4conn.sv =====
// boundary_fill_4conn: top level of the 4-connected boundary fill engine
// depends on bf4_pkg, bf4_ctrl, bf4_dp and bf4_ram
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      command, x_coord, y_coord, pixel_color
//   m_       out        m_valid / m_ready      read_color, filled_count, stack_overflow
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// after reset the frame store is swept to zero, one pixel a cycle; no word is
// accepted during the sweep
// a pixel write or read runs in the exec state and loads the result register
// in the result state; a fill loops pop / latch / fetch / check on the registered
// reads, then tries the four neighbours of each painted pixel in the push state
// a word is accepted while a result waits, then holds until the register frees
module boundary_fill_4conn
    import bf4_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128,
    parameter int STACK_DEPTH  = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [6:0]           s_x_coord,
    input  logic [6:0]           s_y_coord,
    input  logic [COLOR_W-1:0]   s_pixel_color,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_read_color,
    output logic [COUNT_W-1:0]   m_filled_count,
    output logic                 m_stack_overflow,
    // register writes: index 0 fill color, index 1 boundary color
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    // commands from the sequencer, status back from the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: clear sweep, decode, pop / fetch / check / push loop
    bf4_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: frame store, seed stack, counters, output register
    bf4_dp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_command        (s_command),
        .s_x_coord        (s_x_coord),
        .s_y_coord        (s_y_coord),
        .s_pixel_color    (s_pixel_color),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_color     (m_read_color),
        .m_filled_count   (m_filled_count),
        .m_stack_overflow (m_stack_overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

endmodule

// ===== test/boundary_fill_4conn_tb.sv =====
`timescale 1ns / 100ps
// boundary_fill_4conn_tb: self-checking bench for the boundary fill engine
// keeps its own copy of the frame store and drives pixel, fill and register words
// depends on bf4_pkg and boundary_fill_4conn
module boundary_fill_4conn_tb
    import bf4_pkg::*;
();

    localparam int FRAME_W = 128;
    localparam int FRAME_H = 128;
    localparam int STACK_D = 4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'd32767;
    localparam logic [COLOR_W-1:0] BACKGROUND = 24'h000000;
    // command code that the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int DIRECTED_WORDS = 20;
    localparam int RANDOM_WORDS = 75;
    localparam int IDLE_PCT = 35;
    localparam int STALL_AT = 30;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;
    // a fill over the whole frame runs with no handshake
    localparam int WATCHDOG_LIMIT = 1_500_000;

    typedef enum logic {
        JOB_WORD,
        JOB_REG
    } job_kind_t;

    typedef struct packed {
        job_kind_t              kind;
        logic [1:0]             cmd;
        logic [6:0]             x;
        logic [6:0]             y;
        logic [COLOR_W-1:0]     color;
        logic [CFG_IDX_W-1:0]   reg_idx;
    } job_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] painted;
        logic               overflow;
    } result_word_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_command = '0;
    logic [6:0]           s_x_coord = '0;
    logic [6:0]           s_y_coord = '0;
    logic [COLOR_W-1:0]   s_pixel_color = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COLOR_W-1:0]   m_read_color;
    logic [COUNT_W-1:0]   m_filled_count;
    logic                 m_stack_overflow;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]   cfg_data = '0;

    // pending stimulus and results still owed by the block
    job_t         job_q[$];
    result_word_t expected_q[$];
    job_t         cur_word;

    // shadow copy of the block state
    logic [COLOR_W-1:0] shadow_frame [0:FRAME_W*FRAME_H-1];
    logic [13:0]        seed_stack [0:STACK_D-1];
    int                 seed_top = 0;
    logic [COLOR_W-1:0] fill_reg = FILL_COLOR_RESET;
    logic [COLOR_W-1:0] boundary_reg = BOUNDARY_COLOR_RESET;

    // pixels the stimulus ever wrote, so the big fill can start on background
    bit written_px [0:FRAME_W*FRAME_H-1];

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_failures = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  stall_done = 1'b0;
    logic calm;

    // a stretch of results with no idling on either side
    assign calm = (n_results >= 60) && (n_results < 90);

    boundary_fill_4conn u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_x_coord        (s_x_coord),
        .s_y_coord        (s_y_coord),
        .s_pixel_color    (s_pixel_color),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_color     (m_read_color),
        .m_filled_count   (m_filled_count),
        .m_stack_overflow (m_stack_overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // fill prediction
    // ---------------------------------------------------------------

    // push a pixel index on the seed stack, false when the stack is full
    function automatic bit push_seed(input int idx);
        if (seed_top >= STACK_D) begin
            return 1'b0;
        end
        seed_stack[seed_top] = idx[13:0];
        seed_top++;
        return 1'b1;
    endfunction

    // 4-connected fill from a seed, neighbours pushed right, left, down, up
    // off-screen neighbours count as boundary and are never pushed
    function automatic void flood_fill(input logic [6:0] sx, input logic [6:0] sy,
                                       output logic [COUNT_W-1:0] painted,
                                       output logic ovf);
        int idx;
        int px;
        int py;
        painted = '0;
        ovf = 1'b0;
        seed_top = 0;
        void'(push_seed(int'({sy, sx})));
        while (seed_top > 0) begin
            seed_top--;
            idx = int'(seed_stack[seed_top]);
            // boundary and already-filled pixels stop the walk
            if (shadow_frame[idx] != boundary_reg && shadow_frame[idx] != fill_reg) begin
                shadow_frame[idx] = fill_reg;
                if (painted < COUNT_MAX) begin
                    painted++;
                end
                px = idx % FRAME_W;
                py = idx / FRAME_W;
                if (px < FRAME_W - 1 && !push_seed(idx + 1)) begin
                    ovf = 1'b1;
                end
                if (px > 0 && !push_seed(idx - 1)) begin
                    ovf = 1'b1;
                end
                if (py < FRAME_H - 1 && !push_seed(idx + FRAME_W)) begin
                    ovf = 1'b1;
                end
                if (py > 0 && !push_seed(idx - FRAME_W)) begin
                    ovf = 1'b1;
                end
            end
        end
    endfunction

    // result word owed for one accepted input word, shadow state updated
    function automatic result_word_t predict_word(input job_t w);
        result_word_t r;
        logic [COUNT_W-1:0] painted;
        logic ovf;
        r = '0;
        case (w.cmd)
            CMD_WRITE: shadow_frame[{w.y, w.x}] = w.color;
            CMD_READ:  r.color = shadow_frame[{w.y, w.x}];
            CMD_FILL: begin
                flood_fill(w.x, w.y, painted, ovf);
                r.painted = painted;
                r.overflow = ovf;
            end
            default: ;  // unused command leaves everything alone
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic queue_word(input logic [1:0] cmd, input logic [6:0] x, input logic [6:0] y,
                              input logic [COLOR_W-1:0] color);
        job_t j;
        j = '0;
        j.kind = JOB_WORD;
        j.cmd = cmd;
        j.x = x;
        j.y = y;
        j.color = color;
        job_q.push_back(j);
        if (cmd == CMD_WRITE) begin
            written_px[{y, x}] = 1'b1;
        end
        n_queued++;
    endtask

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        job_t j;
        j = '0;
        j.kind = JOB_REG;
        j.reg_idx = idx;
        j.color = data;
        job_q.push_back(j);
    endtask

    // corner of an 8x8 cluster window, often hugging a frame edge
    function automatic logic [6:0] window_origin();
        case ($urandom_range(3))
            0:       return 7'd0;
            1:       return 7'd120;
            default: return 7'($urandom_range(120));
        endcase
    endfunction

    // background stays zero until the last fill: each setting before it keeps it as fill
    // or boundary color, so those fills only walk the small clusters written on top
    initial begin : stimulus
        int phase;
        int next_phase_at;
        int k;
        int n_set;
        logic [6:0] wx;
        logic [6:0] wy;
        logic [6:0] sx;
        logic [6:0] sy;
        logic [COLOR_W-1:0] fc;
        logic [COLOR_W-1:0] bc;
        logic [COLOR_W-1:0] col;

        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        foreach (written_px[i]) written_px[i] = 1'b0;

        // directed: corners, reads after the clear, every command, small fills
        // under the reset colors (fill white, boundary black)
        queue_word(CMD_READ, 7'd0, 7'd0, '0);
        queue_word(CMD_READ, 7'd127, 7'd127, 24'hFFFFFF);
        queue_word(CMD_WRITE, 7'd127, 7'd0, 24'hA5A5A5);
        queue_word(CMD_WRITE, 7'd0, 7'd127, 24'h5A5A5A);
        queue_word(CMD_WRITE, 7'd127, 7'd127, 24'hFFFFFF);
        queue_word(CMD_WRITE, 7'd1, 7'd0, 24'h000001);
        queue_word(CMD_WRITE, 7'd2, 7'd0, 24'h000001);
        queue_word(CMD_WRITE, 7'd0, 7'd0, 24'h000000);
        queue_word(CMD_READ, 7'd127, 7'd0, '0);
        queue_word(CMD_READ, 7'd0, 7'd127, '0);
        queue_word(CMD_READ, 7'd127, 7'd127, '0);
        // corner seed, off-screen neighbours act as boundary
        queue_word(CMD_FILL, 7'd127, 7'd0, '0);
        // two-pixel run, then a seed already in the fill color
        queue_word(CMD_FILL, 7'd1, 7'd0, '0);
        queue_word(CMD_FILL, 7'd2, 7'd0, '0);
        // seed on the boundary color paints nothing
        queue_word(CMD_FILL, 7'd5, 7'd5, '0);
        queue_word(CMD_FILL, 7'd127, 7'd127, 24'hFFFFFF);
        queue_word(CMD_READ, 7'd1, 7'd0, '0);
        // unused command: no change, all-zero result
        queue_word(CMD_UNUSED, 7'd64, 7'd64, 24'h123456);
        queue_word(CMD_READ, 7'd64, 7'd64, '0);
        queue_word(CMD_FILL, 7'd0, 7'd127, '0);

        // random clusters, a new register setting first and then after each twenty or more words
        phase = 0;
        next_phase_at = n_queued;
        fc = FILL_COLOR_RESET;
        bc = BOUNDARY_COLOR_RESET;
        while (n_queued < DIRECTED_WORDS + RANDOM_WORDS) begin
            if (n_queued >= next_phase_at) begin
                case (phase)
                    0: begin
                        fc = 24'h000000;
                        bc = 24'hFFFFFF;
                    end
                    1: begin
                        // fill and boundary equal
                        fc = BACKGROUND;
                        bc = BACKGROUND;
                    end
                    default: begin
                        if ($urandom_range(1) == 1) begin
                            fc = COLOR_W'($urandom);
                            bc = BACKGROUND;
                        end else begin
                            fc = BACKGROUND;
                            bc = COLOR_W'($urandom);
                        end
                    end
                endcase
                queue_reg(REG_FILL_COLOR, fc);
                queue_reg(REG_BOUNDARY_COLOR, bc);
                phase++;
                next_phase_at = n_queued + 20;
            end

            // scatter a cluster, fill it from inside, read it back
            wx = window_origin();
            wy = window_origin();
            n_set = $urandom_range(8, 4);
            for (k = 0; k < n_set; k++) begin
                case ($urandom_range(9))
                    0, 1:    col = fc;
                    2:       col = bc;
                    3:       col = BACKGROUND;
                    default: col = COLOR_W'($urandom);
                endcase
                queue_word(CMD_WRITE, wx + 7'($urandom_range(7)), wy + 7'($urandom_range(7)), col);
            end
            queue_word(CMD_READ, wx + 7'($urandom_range(7)), wy + 7'($urandom_range(7)),
                       COLOR_W'($urandom));
            queue_word(CMD_FILL, wx + 7'($urandom_range(7)), wy + 7'($urandom_range(7)),
                       COLOR_W'($urandom));
            queue_word(CMD_READ, wx + 7'($urandom_range(7)), wy + 7'($urandom_range(7)),
                       COLOR_W'($urandom));
            queue_word(CMD_READ, wx + 7'($urandom_range(7)), wy + 7'($urandom_range(7)),
                       COLOR_W'($urandom));
            // noise anywhere, the unused command included
            if ($urandom_range(99) < 30) begin
                queue_word(2'($urandom_range(3)), 7'($urandom), 7'($urandom),
                           COLOR_W'($urandom));
            end
        end

        // last: background becomes fillable, one fill sweeps nearly the whole
        // frame and runs the seed stack out of room
        fc = COLOR_W'($urandom_range(24'hFFFFFE, 1));
        bc = ~fc;
        queue_reg(REG_FILL_COLOR, fc);
        queue_reg(REG_BOUNDARY_COLOR, bc);
        do begin
            sx = 7'($urandom);
            sy = 7'($urandom);
        end while (written_px[{sy, sx}]);
        queue_word(CMD_FILL, sx, sy, COLOR_W'($urandom));
        queue_word(CMD_READ, sx, sy, COLOR_W'($urandom));
        for (k = 0; k < 3; k++) begin
            queue_word(CMD_READ, 7'($urandom), 7'($urandom), COLOR_W'($urandom));
        end

        // reset once, held from the start and then released
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // everything offered, then everything answered
        while (job_q.size() != 0 || s_valid || cfg_valid) @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_failures == 0) begin
            $display("[boundary_fill_4conn] OK");
        end else begin
            $display("[boundary_fill_4conn] ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // driver: input words and register writes
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : drive
        logic word_busy;
        logic reg_busy;
        logic nxt_s_valid;
        logic nxt_cfg_valid;
        job_t head;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_valid <= 1'b0;
        end else begin
            // word taken: work out what the block owes for it
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_word(cur_word));
                n_accepted <= n_accepted + 1;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FILL_COLOR) begin
                    fill_reg = cfg_data;
                end else begin
                    boundary_reg = cfg_data;
                end
            end

            word_busy = s_valid && !s_ready;
            reg_busy = cfg_valid && !cfg_ready;
            nxt_s_valid = word_busy;
            nxt_cfg_valid = reg_busy;
            if (!word_busy && !reg_busy && job_q.size() != 0) begin
                head = job_q[0];
                if (head.kind == JOB_REG) begin
                    // registers only change with no word in flight
                    if (!(s_valid && s_ready) && n_accepted == n_results) begin
                        void'(job_q.pop_front());
                        nxt_cfg_valid = 1'b1;
                        cfg_index <= head.reg_idx;
                        cfg_data <= head.color;
                    end
                end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
                    void'(job_q.pop_front());
                    cur_word = head;
                    nxt_s_valid = 1'b1;
                    s_command <= head.cmd;
                    s_x_coord <= head.x;
                    s_y_coord <= head.y;
                    s_pixel_color <= head.color;
                end
            end
            s_valid <= nxt_s_valid;
            cfg_valid <= nxt_cfg_valid;
        end
    end

    // ---------------------------------------------------------------
    // result side: back-pressure and checking
    // ---------------------------------------------------------------

    // random stalls plus one long hold so the block fills up and stops taking words
    always @(posedge aclk) begin : accept_results
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!stall_done && n_results >= STALL_AT) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic note_mismatch(input string field, input logic [COLOR_W-1:0] want,
                                 input logic [COLOR_W-1:0] got);
        n_failures++;
        if (n_failures <= 10) begin
            $display("mismatch in %s on result word %0d: expected %h, got %h",
                     field, n_results, want, got);
        end
    endtask

    always @(posedge aclk) begin : check
        result_word_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results <= n_results + 1;
            if (expected_q.size() == 0) begin
                n_failures++;
                if (n_failures <= 10) begin
                    $display("result word %0d arrived with nothing owed", n_results);
                end
            end else begin
                want = expected_q.pop_front();
                if (m_read_color !== want.color) begin
                    note_mismatch("read_color", want.color, m_read_color);
                end
                if (m_filled_count !== want.painted) begin
                    note_mismatch("filled_count", COLOR_W'(want.painted),
                                  COLOR_W'(m_filled_count));
                end
                if (m_stack_overflow !== want.overflow) begin
                    note_mismatch("stack_overflow", COLOR_W'(want.overflow),
                                  COLOR_W'(m_stack_overflow));
                end
            end
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[boundary_fill_4conn] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
sv/bf4_pkg.sv
sv/bf4_ram.sv
sv/bf4_ctrl.sv
sv/bf4_dp.sv
sv/boundary_fill_4conn.sv
test/boundary_fill_4conn_tb.sv
